/* design/dds_setup_command_sequencer_top_macros.svh */
// Assertion macros for the DDS setup command sequencer checker.
// Self-contained; included by the checker file only.
`ifndef DDS_SETUP_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define DDS_SETUP_COMMAND_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DSEQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DSEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dds_seq_pkg.sv */
// Package for the DDS setup command sequencer: types, command codes, the
// reciprocal constants for the division by 10^7 and the word selection.
// No dependencies.
`timescale 1ns / 1ps

package dds_seq_pkg;

    // Field widths of a request and of a command word.
    localparam int FreqWidth   = 27;
    localparam int ScaleWidth  = 24;
    localparam int PhaseWidth  = 12;
    localparam int WordWidth   = 16;
    localparam int TwWidth     = 28;
    localparam int TwHalf      = 14;

    // Configuration register reset value (tuning word per MHz).
    localparam logic [ScaleWidth-1:0] ScaleReset = 24'd3579139;

    // The divisor 10^7 is 2^7 * 78125: the power of two is a shift. The odd
    // part is a multiplication by Recip = ceil(2^57 / 78125) and a shift by
    // 57. Recip * 78125 overshoots 2^57 by 3503, so for any dividend below
    // 2^44 the error stays below one and the floor is exact.
    localparam int ProdWidth     = FreqWidth + ScaleWidth;
    localparam int DivShift      = 7;
    localparam int DividendWidth = ProdWidth - DivShift;
    localparam int RecipWidth    = 41;
    localparam int RecipShift    = 57;
    localparam int RecipSumWidth = DividendWidth + RecipWidth;
    localparam logic [RecipWidth-1:0] Recip = 41'd1844674407371;

    // The dividend and the reciprocal are split into halves so that each
    // partial product stays near 22 x 21 bits.
    localparam int XLoWidth      = 22;
    localparam int XHiWidth      = DividendWidth - XLoWidth;
    localparam int RecipLoWidth  = 21;
    localparam int RecipHiWidth  = RecipWidth - RecipLoWidth;
    localparam logic [RecipLoWidth-1:0] RecipLo = Recip[RecipLoWidth-1:0];
    localparam logic [RecipHiWidth-1:0] RecipHi = Recip[RecipWidth-1:RecipLoWidth];

    // Command codes.
    localparam logic [WordWidth-1:0] CmdReset     = 16'h0100;
    localparam logic [WordWidth-1:0] CmdResetB28  = 16'h2100;
    localparam logic [WordWidth-1:0] TagFreq0     = 16'h4000;
    localparam logic [WordWidth-1:0] TagFreq1     = 16'h8000;
    localparam logic [WordWidth-1:0] TagPhase     = 16'hC000;
    localparam logic [WordWidth-1:0] CtrlB28      = 16'h2000;
    localparam logic [WordWidth-1:0] CtrlFsel     = 16'h0800;
    localparam logic [WordWidth-1:0] CtrlTriangle = 16'h2002;
    localparam logic [WordWidth-1:0] CtrlSine     = 16'h2000;
    localparam logic [WordWidth-1:0] CtrlSquare   = 16'h2028;

    typedef enum logic [1:0] {
        WAVE_TRIANGLE = 2'd0,
        WAVE_SINE     = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_NONE     = 2'd3
    } wave_mode_t;

    // Position of a word within the command sequence of one request.
    typedef enum logic [2:0] {
        WORD_RESET     = 3'd0,
        WORD_RESET_B28 = 3'd1,
        WORD_FREQ_LO   = 3'd2,
        WORD_FREQ_HI   = 3'd3,
        WORD_PHASE     = 3'd4,
        WORD_CONTROL   = 3'd5
    } word_idx_t;

    // Request fields that travel alongside the tuning word computation.
    typedef struct packed {
        logic                  freq_select;
        wave_mode_t            wave_mode;
        logic [PhaseWidth-1:0] phase;
    } req_ctl_t;

    // A finished request handed from the tuning word pipeline to the emitter.
    typedef struct packed {
        logic [TwWidth-1:0] tuning_word;
        req_ctl_t           ctl;
    } tw_item_t;

    typedef struct packed {
        logic [WordWidth-1:0] word;
        logic                 last;
    } cmd_t;

    // Command word and end-of-sequence flag for one position of a request.
    function automatic cmd_t word_for(input word_idx_t idx, input tw_item_t it);
        cmd_t                 cmd;
        logic [WordWidth-1:0] tag;
        logic [WordWidth-1:0] fsel;
        tag  = it.ctl.freq_select ? TagFreq1 : TagFreq0;
        fsel = it.ctl.freq_select ? CtrlFsel : '0;
        cmd  = '{word: CmdReset, last: 1'b0};
        case (idx)
            WORD_RESET: begin
                cmd.word = CmdReset;
            end
            WORD_RESET_B28: begin
                cmd.word = CmdResetB28;
            end
            WORD_FREQ_LO: begin
                cmd.word = {2'b00, it.tuning_word[TwHalf-1:0]} | tag;
            end
            WORD_FREQ_HI: begin
                cmd.word = {2'b00, it.tuning_word[TwWidth-1:TwHalf]} | tag;
            end
            WORD_PHASE: begin
                cmd.word = {4'h0, it.ctl.phase} | TagPhase;
                cmd.last = (it.ctl.wave_mode == WAVE_NONE);
            end
            WORD_CONTROL: begin
                cmd.last = 1'b1;
                case (it.ctl.wave_mode)
                    WAVE_TRIANGLE: cmd.word = CtrlTriangle | fsel;
                    WAVE_SINE:     cmd.word = CtrlSine | fsel;
                    WAVE_SQUARE:   cmd.word = CtrlSquare | fsel;
                    default:       cmd.word = CtrlSine | fsel;
                endcase
            end
            default: begin
                cmd.word = CmdReset;
            end
        endcase
        return cmd;
    endfunction

endpackage

/* design/dds_seq_tw_pipe.sv */
// Tuning word pipeline: input register, product stage, partial products of
// the reciprocal multiplication and the quotient stage. Depends on dds_seq_pkg.
`timescale 1ns / 1ps

module dds_seq_tw_pipe (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [dds_seq_pkg::ScaleWidth-1:0]  tuning_scale,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dds_seq_pkg::FreqWidth-1:0]   in_freq,
    input  dds_seq_pkg::req_ctl_t               in_ctl,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dds_seq_pkg::tw_item_t               out_item
);

    localparam int PpLlWidth = dds_seq_pkg::XLoWidth + dds_seq_pkg::RecipLoWidth;
    localparam int PpLhWidth = dds_seq_pkg::XLoWidth + dds_seq_pkg::RecipHiWidth;
    localparam int PpHlWidth = dds_seq_pkg::XHiWidth + dds_seq_pkg::RecipLoWidth;
    localparam int PpHhWidth = dds_seq_pkg::XHiWidth + dds_seq_pkg::RecipHiWidth;
    localparam int SumWidth  = dds_seq_pkg::RecipSumWidth;

    // Input register
    logic                                a_valid_reg;
    logic [dds_seq_pkg::FreqWidth-1:0]   a_freq_reg;
    dds_seq_pkg::req_ctl_t               a_ctl_reg;

    // Product register, already shifted by the power-of-two part of 10^7
    logic                                    b_valid_reg;
    logic [dds_seq_pkg::DividendWidth-1:0]   b_x_reg;
    dds_seq_pkg::req_ctl_t                   b_ctl_reg;

    // Partial products of the dividend and the reciprocal
    logic                    c_valid_reg;
    logic [PpLlWidth-1:0]    c_pp_ll_reg;
    logic [PpLhWidth-1:0]    c_pp_lh_reg;
    logic [PpHlWidth-1:0]    c_pp_hl_reg;
    logic [PpHhWidth-1:0]    c_pp_hh_reg;
    dds_seq_pkg::req_ctl_t   c_ctl_reg;

    // Quotient register
    logic                                d_valid_reg;
    logic [dds_seq_pkg::TwWidth-1:0]     d_tw_reg;
    dds_seq_pkg::req_ctl_t               d_ctl_reg;

    logic                                 a_adv;
    logic                                 b_adv;
    logic                                 c_adv;
    logic                                 d_adv;
    logic [dds_seq_pkg::ProdWidth-1:0]    product;
    logic [dds_seq_pkg::XLoWidth-1:0]     x_lo;
    logic [dds_seq_pkg::XHiWidth-1:0]     x_hi;
    logic [SumWidth-1:0]                  recip_sum;

    // A stage moves on when it is empty or when the stage after it moves.
    assign d_adv    = !d_valid_reg || out_ready;
    assign c_adv    = !c_valid_reg || d_adv;
    assign b_adv    = !b_valid_reg || c_adv;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;

    // Valid flags of all stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (a_adv) begin
                a_valid_reg <= in_valid;
            end
            if (b_adv) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_adv) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_adv) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (a_adv && in_valid) begin
            a_freq_reg <= in_freq;
            a_ctl_reg  <= in_ctl;
        end
    end

    // Product stage: 27 x 24 bit multiply
    assign product = dds_seq_pkg::ProdWidth'(a_freq_reg)
                   * dds_seq_pkg::ProdWidth'(tuning_scale);

    always_ff @(posedge aclk) begin
        if (b_adv && a_valid_reg) begin
            b_x_reg   <= product[dds_seq_pkg::ProdWidth-1:dds_seq_pkg::DivShift];
            b_ctl_reg <= a_ctl_reg;
        end
    end

    // Partial products: each half of the dividend times each half of the
    // reciprocal.
    assign x_lo = b_x_reg[dds_seq_pkg::XLoWidth-1:0];
    assign x_hi = b_x_reg[dds_seq_pkg::DividendWidth-1:dds_seq_pkg::XLoWidth];

    always_ff @(posedge aclk) begin
        if (c_adv && b_valid_reg) begin
            c_pp_ll_reg <= PpLlWidth'(x_lo) * PpLlWidth'(dds_seq_pkg::RecipLo);
            c_pp_lh_reg <= PpLhWidth'(x_lo) * PpLhWidth'(dds_seq_pkg::RecipHi);
            c_pp_hl_reg <= PpHlWidth'(x_hi) * PpHlWidth'(dds_seq_pkg::RecipLo);
            c_pp_hh_reg <= PpHhWidth'(x_hi) * PpHhWidth'(dds_seq_pkg::RecipHi);
            c_ctl_reg   <= b_ctl_reg;
        end
    end

    // Quotient stage: align and add the partial products, then keep the bits
    // above the reciprocal shift.
    assign recip_sum = SumWidth'(c_pp_ll_reg)
                     + (SumWidth'(c_pp_lh_reg) << dds_seq_pkg::RecipLoWidth)
                     + (SumWidth'(c_pp_hl_reg) << dds_seq_pkg::XLoWidth)
                     + (SumWidth'(c_pp_hh_reg)
                        << (dds_seq_pkg::XLoWidth + dds_seq_pkg::RecipLoWidth));

    always_ff @(posedge aclk) begin
        if (d_adv && c_valid_reg) begin
            d_tw_reg  <= recip_sum[SumWidth-1:dds_seq_pkg::RecipShift];
            d_ctl_reg <= c_ctl_reg;
        end
    end

    // The dividend is below 2^44, so the quotient always fits 28 bits and
    // never reaches the 28-bit maximum of 2^28-1.
    assign out_valid              = d_valid_reg;
    assign out_item.tuning_word   = d_tw_reg;
    assign out_item.ctl           = d_ctl_reg;

endmodule

/* design/dds_seq_emitter.sv */
// Command word emitter: holds one finished request and presents its command
// words in order from an output register. Depends on dds_seq_pkg.
`timescale 1ns / 1ps

module dds_seq_emitter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dds_seq_pkg::tw_item_t               in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dds_seq_pkg::WordWidth-1:0]   out_word,
    output logic                                out_last
);

    logic                        busy_reg,  busy_next;
    dds_seq_pkg::tw_item_t       item_reg,  item_next;
    dds_seq_pkg::word_idx_t      idx_reg,   idx_next;
    dds_seq_pkg::cmd_t           cmd_reg,   cmd_next;
    logic                        take;

    assign take     = busy_reg && out_ready;
    assign in_ready = !busy_reg || (take && cmd_reg.last);

    // Load a new request after the last word of the previous one has gone,
    // otherwise step to the next word on each completed transaction.
    always_comb begin
        busy_next = busy_reg;
        item_next = item_reg;
        idx_next  = idx_reg;
        cmd_next  = cmd_reg;
        if (in_valid && in_ready) begin
            busy_next = 1'b1;
            item_next = in_item;
            idx_next  = dds_seq_pkg::WORD_RESET;
            cmd_next  = dds_seq_pkg::word_for(dds_seq_pkg::WORD_RESET, in_item);
        end else if (take && !cmd_reg.last) begin
            idx_next  = dds_seq_pkg::word_idx_t'(idx_reg + 3'd1);
            cmd_next  = dds_seq_pkg::word_for(idx_next, item_reg);
        end else if (take) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
    end

    assign out_valid = busy_reg;
    assign out_word  = cmd_reg.word;
    assign out_last  = cmd_reg.last;

endmodule

/* design/dds_setup_command_sequencer_top.sv */
// Top level of the DDS setup command sequencer: configuration register,
// tuning word pipeline and command word emitter. Depends on dds_seq_pkg,
// dds_seq_tw_pipe and dds_seq_emitter.
`timescale 1ns / 1ps

// Each setup request becomes five or six 16-bit command words: reset, reset
// with two-word write, the low and high 14 bits of the tuning word tagged with
// the register select, the phase word and, unless wave mode 3, a control word;
// m_tlast marks the final word. The tuning word is
// floor(frequency_tenths * tuning_scale / 10^7), computed by a 27 x 24 bit
// multiply, a shift by seven and a multiplication by a fixed reciprocal of
// 78125 split into four partial products. Words leave at one per cycle
// while m_tready is high; the request rate is set by the emitter's single
// output register, which loads the next request as the last word of the
// previous one is taken. The pipeline buffers up to four further requests,
// so s_tready stays high until those are full and then follows the
// emitter. tuning_scale is written through cfg_wr_en / cfg_wr_data and must
// only be changed while no request is in flight.

module dds_setup_command_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,   // tuning_scale
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // [26:0] frequency_tenths, [38:27] phase, [39] zero
    input  logic [2:0]  s_tuser,       // [0] freq_select, [2:1] wave_mode
    // Command word stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [15:0] command_word
    output logic        m_tlast        // last_word
);

    logic [dds_seq_pkg::ScaleWidth-1:0] tuning_scale_reg;
    dds_seq_pkg::req_ctl_t              req_ctl;
    dds_seq_pkg::tw_item_t              tw_item;
    logic                               tw_valid;
    logic                               tw_ready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tuning_scale_reg <= dds_seq_pkg::ScaleReset;
        end else if (cfg_wr_en) begin
            tuning_scale_reg <= cfg_wr_data;
        end
    end

    // Unpack the request side-band fields
    assign req_ctl.freq_select = s_tuser[0];
    assign req_ctl.wave_mode   = dds_seq_pkg::wave_mode_t'(s_tuser[2:1]);
    assign req_ctl.phase       = s_tdata[38:27];

    dds_seq_tw_pipe u_tw_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tuning_scale (tuning_scale_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_freq      (s_tdata[26:0]),
        .in_ctl       (req_ctl),
        .out_valid    (tw_valid),
        .out_ready    (tw_ready),
        .out_item     (tw_item)
    );

    dds_seq_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tw_valid),
        .in_ready  (tw_ready),
        .in_item   (tw_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

/* design/dds_seq_checker.sv */
// Port-level checker for the DDS setup command sequencer, bound to the top.
// Depends on dds_seq_pkg and dds_setup_command_sequencer_top_macros.svh.
`timescale 1ns / 1ps
`include "dds_setup_command_sequencer_top_macros.svh"

module dds_seq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled command word holds until its transaction completes.
    `DSEQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled command word changed")

    // The next word after a sequence ends, if any, starts a new sequence.
    `DSEQ_ASSERT_NEXT(a_seq_start, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid || m_tdata == dds_seq_pkg::CmdReset, "sequence did not start with reset")

    // The reset word is followed at once by the two-word write command.
    `DSEQ_ASSERT_NEXT(a_reset_pair, aclk, aresetn, m_tvalid && m_tready && m_tdata == dds_seq_pkg::CmdReset, m_tvalid && m_tdata == dds_seq_pkg::CmdResetB28 && !m_tlast, "reset not followed by two-word write")

    // Only a phase word or a control word may close a sequence.
    `DSEQ_ASSERT_SAME(a_last_kind, aclk, aresetn, m_tvalid && m_tlast, ((m_tdata & dds_seq_pkg::TagPhase) == dds_seq_pkg::TagPhase) || (((m_tdata & dds_seq_pkg::TagPhase) == 16'h0000) && ((m_tdata & dds_seq_pkg::CtrlB28) == dds_seq_pkg::CtrlB28)), "sequence closed on a wrong word")

endmodule

bind dds_setup_command_sequencer_top dds_seq_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
